/* sv/xed_pkg.sv */
package xed_pkg;

    localparam int unsigned CP_W  = 21;
    localparam int unsigned ERR_W = 3;
    localparam int unsigned MODE_W = 3;

    localparam logic [MODE_W-1:0] MODE_TEXT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_AMP  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_HASH = 3'd2;
    localparam logic [MODE_W-1:0] MODE_HEX  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DEC  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_NAME = 3'd5;

    localparam logic [ERR_W-1:0] ERR_OK   = 3'd0;
    localparam logic [ERR_W-1:0] ERR_HEX  = 3'd1;
    localparam logic [ERR_W-1:0] ERR_DEC  = 3'd2;
    localparam logic [ERR_W-1:0] ERR_NAME = 3'd3;
    localparam logic [ERR_W-1:0] ERR_BIG  = 3'd4;

    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [CP_W-1:0] CP_QMARK = 21'h3F;
    localparam logic [21:0] CP_LIMIT = 22'h10FFFF;
    localparam logic [21:0] CP_OVER  = 22'h110000;

    localparam int unsigned ENT_COUNT = 254;
    localparam int unsigned ENT_CHARS = 8;

    typedef struct packed {
        logic [CP_W-1:0]  code_point;
        logic [ERR_W-1:0] error_kind;
    } result_t;

    // Front-to-back command: either a finished result, or a name to look up.
    typedef struct packed {
        logic                  is_name;
        result_t               res;
        logic                  too_long;
        logic [5:0]            name_len;
        logic [8*32-1:0]       name_bytes;
    } cmd_t;

    typedef struct packed {
        logic [8*ENT_CHARS-1:0] txt;
        logic [3:0]             len;
        logic [15:0]            cp;
    } ent_t;

    function automatic ent_t mk(input string s, input logic [15:0] cp);
        ent_t e;
        e.txt = '0;
        e.len = 4'(s.len());
        for (int i = 0; i < ENT_CHARS; i++)
        begin
            if (i < s.len())
            begin
                e.txt[8*i +: 8] = s[i];
            end
        end
        e.cp = cp;
        return e;
    endfunction

    function automatic ent_t ent(input int unsigned i);
        case (i)
            0: return mk("quot",16'h22);   1: return mk("amp",16'h26);
            2: return mk("apos",16'h27);   3: return mk("lt",16'h3C);
            4: return mk("gt",16'h3E);     5: return mk("nbsp",16'hA0);
            6: return mk("iexcl",16'hA1);  7: return mk("cent",16'hA2);
            8: return mk("pound",16'hA3);  9: return mk("curren",16'hA4);
            10: return mk("yen",16'hA5);   11: return mk("brvbar",16'hA6);
            12: return mk("sect",16'hA7);  13: return mk("uml",16'hA8);
            14: return mk("copy",16'hA9);  15: return mk("ordf",16'hAA);
            16: return mk("laquo",16'hAB); 17: return mk("not",16'hAC);
            18: return mk("shy",16'hAD);   19: return mk("reg",16'hAE);
            20: return mk("macr",16'hAF);  21: return mk("deg",16'hB0);
            22: return mk("plusmn",16'hB1); 23: return mk("sup2",16'hB2);
            24: return mk("sup3",16'hB3);  25: return mk("acute",16'hB4);
            26: return mk("micro",16'hB5); 27: return mk("para",16'hB6);
            28: return mk("middot",16'hB7); 29: return mk("cedil",16'hB8);
            30: return mk("sup1",16'hB9);  31: return mk("ordm",16'hBA);
            32: return mk("raquo",16'hBB); 33: return mk("frac14",16'hBC);
            34: return mk("frac12",16'hBD); 35: return mk("frac34",16'hBE);
            36: return mk("iquest",16'hBF); 37: return mk("Agrave",16'hC0);
            38: return mk("Aacute",16'hC1); 39: return mk("Acirc",16'hC2);
            40: return mk("Atilde",16'hC3); 41: return mk("Auml",16'hC4);
            42: return mk("Aring",16'hC5); 43: return mk("AElig",16'hC6);
            44: return mk("Ccedil",16'hC7); 45: return mk("Egrave",16'hC8);
            46: return mk("Eacute",16'hC9); 47: return mk("Ecirc",16'hCA);
            48: return mk("Euml",16'hCB);  49: return mk("Igrave",16'hCC);
            50: return mk("Iacute",16'hCD); 51: return mk("Icirc",16'hCE);
            52: return mk("Iuml",16'hCF);  53: return mk("ETH",16'hD0);
            54: return mk("Ntilde",16'hD1); 55: return mk("Ograve",16'hD2);
            56: return mk("Oacute",16'hD3); 57: return mk("Ocirc",16'hD4);
            58: return mk("Otilde",16'hD5); 59: return mk("Ouml",16'hD6);
            60: return mk("times",16'hD7); 61: return mk("Oslash",16'hD8);
            62: return mk("Ugrave",16'hD9); 63: return mk("Uacute",16'hDA);
            64: return mk("Ucirc",16'hDB); 65: return mk("Uuml",16'hDC);
            66: return mk("Yacute",16'hDD); 67: return mk("THORN",16'hDE);
            68: return mk("szlig",16'hDF); 69: return mk("agrave",16'hE0);
            70: return mk("aacute",16'hE1); 71: return mk("acirc",16'hE2);
            72: return mk("atilde",16'hE3); 73: return mk("auml",16'hE4);
            74: return mk("aring",16'hE5); 75: return mk("aelig",16'hE6);
            76: return mk("ccedil",16'hE7); 77: return mk("egrave",16'hE8);
            78: return mk("eacute",16'hE9); 79: return mk("ecirc",16'hEA);
            80: return mk("euml",16'hEB);  81: return mk("igrave",16'hEC);
            82: return mk("iacute",16'hED); 83: return mk("icirc",16'hEE);
            84: return mk("iuml",16'hEF);  85: return mk("eth",16'hF0);
            86: return mk("ntilde",16'hF1); 87: return mk("ograve",16'hF2);
            88: return mk("oacute",16'hF3); 89: return mk("ocirc",16'hF4);
            90: return mk("otilde",16'hF5); 91: return mk("ouml",16'hF6);
            92: return mk("divide",16'hF7); 93: return mk("oslash",16'hF8);
            94: return mk("ugrave",16'hF9); 95: return mk("uacute",16'hFA);
            96: return mk("ucirc",16'hFB); 97: return mk("uuml",16'hFC);
            98: return mk("yacute",16'hFD); 99: return mk("thorn",16'hFE);
            100: return mk("yuml",16'hFF); 101: return mk("OElig",16'h152);
            102: return mk("oelig",16'h153); 103: return mk("Scaron",16'h160);
            104: return mk("scaron",16'h161); 105: return mk("Yuml",16'h178);
            106: return mk("fnof",16'h192); 107: return mk("circ",16'h2C6);
            108: return mk("tilde",16'h2DC); 109: return mk("Alpha",16'h391);
            110: return mk("Beta",16'h392); 111: return mk("Gamma",16'h393);
            112: return mk("Delta",16'h394); 113: return mk("Epsilon",16'h395);
            114: return mk("Zeta",16'h396); 115: return mk("Eta",16'h397);
            116: return mk("Theta",16'h398); 117: return mk("Iota",16'h399);
            118: return mk("Kappa",16'h39A); 119: return mk("Lambda",16'h39B);
            120: return mk("Mu",16'h39C);  121: return mk("Nu",16'h39D);
            122: return mk("Xi",16'h39E);  123: return mk("Omicron",16'h39F);
            124: return mk("Pi",16'h3A0);  125: return mk("Rho",16'h3A1);
            126: return mk("Sigma",16'h3A3); 127: return mk("Tau",16'h3A4);
            128: return mk("Upsilon",16'h3A5); 129: return mk("Phi",16'h3A6);
            130: return mk("Chi",16'h3A7); 131: return mk("Psi",16'h3A8);
            132: return mk("Omega",16'h3A9); 133: return mk("alpha",16'h3B1);
            134: return mk("beta",16'h3B2); 135: return mk("gamma",16'h3B3);
            136: return mk("delta",16'h3B4); 137: return mk("epsilon",16'h3B5);
            138: return mk("zeta",16'h3B6); 139: return mk("eta",16'h3B7);
            140: return mk("theta",16'h3B8); 141: return mk("iota",16'h3B9);
            142: return mk("kappa",16'h3BA); 143: return mk("lambda",16'h3BB);
            144: return mk("mu",16'h3BC);  145: return mk("nu",16'h3BD);
            146: return mk("xi",16'h3BE);  147: return mk("omicron",16'h3BF);
            148: return mk("pi",16'h3C0);  149: return mk("rho",16'h3C1);
            150: return mk("sigmaf",16'h3C2); 151: return mk("sigma",16'h3C3);
            152: return mk("tau",16'h3C4); 153: return mk("upsilon",16'h3C5);
            154: return mk("phi",16'h3C6); 155: return mk("chi",16'h3C7);
            156: return mk("psi",16'h3C8); 157: return mk("omega",16'h3C9);
            158: return mk("thetasym",16'h3D1); 159: return mk("upsih",16'h3D2);
            160: return mk("piv",16'h3D6); 161: return mk("ensp",16'h2002);
            162: return mk("emsp",16'h2003); 163: return mk("thinsp",16'h2009);
            164: return mk("zwnj",16'h200C); 165: return mk("zwj",16'h200D);
            166: return mk("lrm",16'h200E); 167: return mk("rlm",16'h200F);
            168: return mk("ndash",16'h2013); 169: return mk("mdash",16'h2014);
            170: return mk("lsquo",16'h2018); 171: return mk("rsquo",16'h2019);
            172: return mk("sbquo",16'h201A); 173: return mk("ldquo",16'h201C);
            174: return mk("rdquo",16'h201D); 175: return mk("bdquo",16'h201E);
            176: return mk("dagger",16'h2020); 177: return mk("Dagger",16'h2021);
            178: return mk("bull",16'h2022); 179: return mk("hellip",16'h2026);
            180: return mk("permil",16'h2030); 181: return mk("prime",16'h2032);
            182: return mk("Prime",16'h2033); 183: return mk("lsaquo",16'h2039);
            184: return mk("rsaquo",16'h203A); 185: return mk("oline",16'h203E);
            186: return mk("frasl",16'h2044); 187: return mk("euro",16'h20AC);
            188: return mk("image",16'h2111); 189: return mk("weierp",16'h2118);
            190: return mk("real",16'h211C); 191: return mk("trade",16'h2122);
            192: return mk("alefsym",16'h2135); 193: return mk("larr",16'h2190);
            194: return mk("uarr",16'h2191); 195: return mk("rarr",16'h2192);
            196: return mk("darr",16'h2193); 197: return mk("harr",16'h2194);
            198: return mk("crarr",16'h21B5); 199: return mk("lArr",16'h21D0);
            200: return mk("uArr",16'h21D1); 201: return mk("rArr",16'h21D2);
            202: return mk("dArr",16'h21D3); 203: return mk("hArr",16'h21D4);
            204: return mk("forall",16'h2200); 205: return mk("part",16'h2202);
            206: return mk("exist",16'h2203); 207: return mk("empty",16'h2205);
            208: return mk("nabla",16'h2207); 209: return mk("isin",16'h2208);
            210: return mk("notin",16'h2209); 211: return mk("ni",16'h220B);
            212: return mk("prod",16'h220F); 213: return mk("sum",16'h2211);
            214: return mk("minus",16'h2212); 215: return mk("lowast",16'h2217);
            216: return mk("radic",16'h221A); 217: return mk("prop",16'h221D);
            218: return mk("infin",16'h221E); 219: return mk("ang",16'h2220);
            220: return mk("and",16'h2227); 221: return mk("or",16'h2228);
            222: return mk("cap",16'h2229); 223: return mk("cup",16'h222A);
            224: return mk("int",16'h222B); 225: return mk("there4",16'h2234);
            226: return mk("sim",16'h223C); 227: return mk("cong",16'h2245);
            228: return mk("asymp",16'h2248); 229: return mk("ne",16'h2260);
            230: return mk("equiv",16'h2261); 231: return mk("le",16'h2264);
            232: return mk("ge",16'h2265); 233: return mk("sub",16'h2282);
            234: return mk("sup",16'h2283); 235: return mk("nsub",16'h2284);
            236: return mk("sube",16'h2286); 237: return mk("supe",16'h2287);
            238: return mk("oplus",16'h2295); 239: return mk("otimes",16'h2297);
            240: return mk("perp",16'h22A5); 241: return mk("sdot",16'h22C5);
            242: return mk("vellip",16'h22EE); 243: return mk("lceil",16'h2308);
            244: return mk("rceil",16'h2309); 245: return mk("lfloor",16'h230A);
            246: return mk("rfloor",16'h230B); 247: return mk("lang",16'h2329);
            248: return mk("rang",16'h232A); 249: return mk("loz",16'h25CA);
            250: return mk("spades",16'h2660); 251: return mk("clubs",16'h2663);
            252: return mk("hearts",16'h2665); 253: return mk("diams",16'h2666);
            default: return '0;
        endcase
    endfunction

endpackage

/* sv/xml_entity_decoder.sv */
// XML character entity decoder.
// Input queue side: present text_byte with push; a transfer happens at a
// rising clock edge with push high and full low. One byte can be taken
// every cycle while full is low.
// Result queue side: while empty is low, code_point and error_kind show
// the oldest result; pop with empty low completes its transfer.
// Plain bytes give one result each; the bytes of a reference give a single
// result at the closing ';' or at the first bad digit.
// The byte that ends a result passes through the front stage, the name
// lookup stage and the result queue write before the result is visible.
// Throughput: one byte per cycle while full is low, limited by the front
// scanner, which updates its mode, accumulator and name buffer once per byte.
// The name lookup compares the collected name against every table entry
// at once in the back stage.
// Configuration: the user writes skip_unknown through cfg_valid/cfg_ready
// only while the block is idle; the block does not enforce it. cfg_ready
// is always high. Reset clears the scanner to text mode, empties the queue
// and clears skip_unknown. When the receiver stalls, results pile up in the
// queue and full rises early enough that results still in flight always fit.
module xml_entity_decoder #(
    parameter int unsigned MAX_NAME_LEN  = 8,
    parameter int unsigned TABLE_ENTRIES = 256
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [7:0]                  text_byte,
    output logic                        empty,
    input  logic                        pop,
    output logic [xed_pkg::CP_W-1:0]    code_point,
    output logic [xed_pkg::ERR_W-1:0]   error_kind,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        cfg_data
);

    logic             skip_reg;
    logic             accept;
    logic             cmd_valid;
    xed_pkg::cmd_t    cmd;
    logic             res_valid;
    xed_pkg::result_t res;
    xed_pkg::result_t head;
    logic             almost_full;

    assign cfg_ready = 1'b1;
    assign accept    = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            skip_reg <= cfg_data;
        end
    end

    xed_front #(.MAX_NAME_LEN(MAX_NAME_LEN)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .in_byte   (text_byte),
        .cmd_valid (cmd_valid),
        .cmd       (cmd)
    );

    xed_back #(.MAX_NAME_LEN(MAX_NAME_LEN), .TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .skip_unknown (skip_reg),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .res_valid    (res_valid),
        .res          (res)
    );

    // Two results can be in flight past the full check, so the queue
    // reports full with two slots still free.
    xed_fifo #(.DEPTH(4)) u_fifo (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (res_valid),
        .wr_data     (res),
        .rd_en       (pop && !empty),
        .empty       (empty),
        .almost_full (almost_full),
        .rd_data     (head)
    );

    assign full       = almost_full;
    assign code_point = head.code_point;
    assign error_kind = head.error_kind;

endmodule

/* sv/xed_front.sv */
module xed_front #(
    parameter int unsigned MAX_NAME_LEN = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [7:0]           in_byte,
    output logic                 cmd_valid,
    output xed_pkg::cmd_t        cmd
);

    localparam int unsigned LEN_W = $clog2(MAX_NAME_LEN + 2);
    localparam int unsigned IDX_W = $clog2(MAX_NAME_LEN);

    logic [xed_pkg::MODE_W-1:0] mode_reg, mode_next;
    logic [21:0]                acc_reg, acc_next;
    logic [LEN_W-1:0]           len_reg, len_next;
    logic [7:0]                 name_reg [MAX_NAME_LEN];

    logic [3:0]                 hex_d;
    logic                       hex_ok;
    logic                       dec_ok;
    logic [25:0]                grown;
    logic                       emit;
    logic                       store;
    logic [LEN_W-1:0]           name_len_now;
    xed_pkg::cmd_t              c;

    always_comb
    begin
        hex_ok = 1'b1;
        hex_d  = 4'd0;
        if (in_byte inside {[8'h30:8'h39]})
        begin
            hex_d = 4'(in_byte - 8'h30);
        end
        else if (in_byte inside {[8'h61:8'h66]})
        begin
            hex_d = 4'(in_byte - 8'h57);
        end
        else if (in_byte inside {[8'h41:8'h46]})
        begin
            hex_d = 4'(in_byte - 8'h37);
        end
        else
        begin
            hex_ok = 1'b0;
        end
        dec_ok = in_byte inside {[8'h30:8'h39]};
    end

    always_comb
    begin
        if (mode_reg == xed_pkg::MODE_HEX)
        begin
            grown = {acc_reg, 4'd0} + 26'(hex_d);
        end
        else
        begin
            grown = 26'({acc_reg, 3'd0}) + 26'({acc_reg, 1'b0}) + 26'(hex_d);
        end
    end

    always_comb
    begin
        mode_next    = mode_reg;
        acc_next     = acc_reg;
        len_next     = len_reg;
        emit         = 1'b0;
        store        = 1'b0;
        name_len_now = len_reg;
        c            = '0;
        c.res.error_kind = xed_pkg::ERR_OK;
        case (mode_reg)
            xed_pkg::MODE_TEXT:
            begin
                if (in_byte == xed_pkg::CH_AMP)
                begin
                    mode_next = xed_pkg::MODE_AMP;
                    acc_next  = '0;
                    len_next  = '0;
                end
                else
                begin
                    emit = 1'b1;
                    c.res.code_point = xed_pkg::CP_W'(in_byte);
                end
            end
            xed_pkg::MODE_HASH:
            begin
                if (in_byte == xed_pkg::CH_X)
                begin
                    mode_next = xed_pkg::MODE_HEX;
                    acc_next  = '0;
                end
                else if (dec_ok)
                begin
                    mode_next = xed_pkg::MODE_DEC;
                    acc_next  = 22'(hex_d);
                end
                else
                begin
                    emit = 1'b1;
                    c.res.error_kind = xed_pkg::ERR_DEC;
                end
            end
            xed_pkg::MODE_HEX, xed_pkg::MODE_DEC:
            begin
                if (in_byte == xed_pkg::CH_SEMI)
                begin
                    emit = 1'b1;
                    if (acc_reg > xed_pkg::CP_LIMIT)
                    begin
                        c.res.error_kind = xed_pkg::ERR_BIG;
                    end
                    else
                    begin
                        c.res.code_point = acc_reg[xed_pkg::CP_W-1:0];
                    end
                end
                else if (mode_reg == xed_pkg::MODE_HEX && !hex_ok)
                begin
                    emit = 1'b1;
                    c.res.error_kind = xed_pkg::ERR_HEX;
                end
                else if (mode_reg == xed_pkg::MODE_DEC && !dec_ok)
                begin
                    emit = 1'b1;
                    c.res.error_kind = xed_pkg::ERR_DEC;
                end
                else if (grown > 26'(xed_pkg::CP_LIMIT))
                begin
                    acc_next = xed_pkg::CP_OVER;
                end
                else
                begin
                    acc_next = grown[21:0];
                end
            end
            xed_pkg::MODE_AMP, xed_pkg::MODE_NAME:
            begin
                if (mode_reg == xed_pkg::MODE_AMP)
                begin
                    name_len_now = '0;
                end
                if (mode_reg == xed_pkg::MODE_AMP && in_byte == xed_pkg::CH_HASH)
                begin
                    mode_next = xed_pkg::MODE_HASH;
                end
                else if (in_byte == xed_pkg::CH_SEMI)
                begin
                    emit      = 1'b1;
                    c.is_name = 1'b1;
                    c.too_long = name_len_now > LEN_W'(MAX_NAME_LEN);
                    c.name_len = 6'(name_len_now);
                    for (int i = 0; i < MAX_NAME_LEN; i++)
                    begin
                        c.name_bytes[8*i +: 8] = name_reg[i];
                    end
                end
                else
                begin
                    mode_next = xed_pkg::MODE_NAME;
                    if (name_len_now < LEN_W'(MAX_NAME_LEN))
                    begin
                        store    = 1'b1;
                        len_next = name_len_now + LEN_W'(1);
                    end
                    else
                    begin
                        len_next = LEN_W'(MAX_NAME_LEN + 1);
                    end
                end
            end
            default:
            begin
                mode_next = xed_pkg::MODE_TEXT;
            end
        endcase
        if (emit)
        begin
            mode_next = xed_pkg::MODE_TEXT;
            acc_next  = '0;
            len_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= xed_pkg::MODE_TEXT;
            acc_reg   <= '0;
            len_reg   <= '0;
            cmd_valid <= 1'b0;
        end
        else
        begin
            cmd_valid <= in_valid && emit;
            if (in_valid)
            begin
                mode_reg <= mode_next;
                acc_reg  <= acc_next;
                len_reg  <= len_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && emit)
        begin
            cmd <= c;
        end
        if (in_valid && store)
        begin
            name_reg[name_len_now[IDX_W-1:0]] <= in_byte;
        end
    end

endmodule

/* sv/xed_back.sv */
module xed_back #(
    parameter int unsigned MAX_NAME_LEN  = 8,
    parameter int unsigned TABLE_ENTRIES = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               skip_unknown,
    input  logic               cmd_valid,
    input  xed_pkg::cmd_t      cmd,
    output logic               res_valid,
    output xed_pkg::result_t   res
);

    localparam int unsigned LIM = (xed_pkg::ENT_COUNT < TABLE_ENTRIES) ?
                                  xed_pkg::ENT_COUNT : TABLE_ENTRIES;

    logic [15:0]                     hit_cp;
    xed_pkg::ent_t                   e;
    logic [8*xed_pkg::ENT_CHARS-1:0] len_mask;

    // Parallel compare against every table entry; names are unique.
    // Buffer bytes past the name length are stale and are masked off.
    always_comb
    begin
        hit_cp   = '0;
        e        = '0;
        len_mask = '0;
        for (int i = 0; i < LIM; i++)
        begin
            e = xed_pkg::ent(i);
            len_mask = ~({8*xed_pkg::ENT_CHARS{1'b1}} << (8*e.len));
            if (!cmd.too_long && cmd.name_len == 6'(e.len) &&
                (cmd.name_bytes[8*xed_pkg::ENT_CHARS-1:0] & len_mask) ==
                (e.txt & len_mask) &&
                (MAX_NAME_LEN >= e.len))
            begin
                hit_cp = hit_cp | e.cp;
            end
        end
        if (cmd.name_len > 6'(xed_pkg::ENT_CHARS))
        begin
            hit_cp = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid <= 1'b0;
        end
        else
        begin
            res_valid <= cmd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid)
        begin
            if (!cmd.is_name)
            begin
                res <= cmd.res;
            end
            else if (hit_cp != '0)
            begin
                res <= '{code_point: xed_pkg::CP_W'(hit_cp), error_kind: xed_pkg::ERR_OK};
            end
            else if (skip_unknown)
            begin
                res <= '{code_point: xed_pkg::CP_QMARK, error_kind: xed_pkg::ERR_OK};
            end
            else
            begin
                res <= '{code_point: '0, error_kind: xed_pkg::ERR_NAME};
            end
        end
    end

endmodule

/* sv/xed_fifo.sv */
module xed_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  xed_pkg::result_t wr_data,
    input  logic             rd_en,
    output logic             empty,
    output logic             almost_full,
    output xed_pkg::result_t rd_data
);

    localparam int unsigned AW = $clog2(DEPTH);

    xed_pkg::result_t mem [DEPTH];
    logic [AW-1:0]    wp_reg, rp_reg;
    logic [AW:0]      cnt_reg;

    assign empty       = (cnt_reg == '0);
    assign almost_full = (cnt_reg >= (AW+1)'(DEPTH - 2));
    assign rd_data     = mem[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wp_reg <= wp_reg + AW'(1);
            end
            if (rd_en)
            begin
                rp_reg <= rp_reg + AW'(1);
            end
            cnt_reg <= cnt_reg + (AW+1)'(wr_en) - (AW+1)'(rd_en);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wp_reg] <= wr_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (cnt_reg < (AW+1)'(DEPTH)))
        else $error("result queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> !empty)
        else $error("result queue underflow");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && !rd_en) |=> (cnt_reg == $past(cnt_reg) + (AW+1)'(1)))
        else $error("queue count did not advance");

endmodule
